FILE: sv/wlo_pkg.sv
// Shared types, constants and lookup function of the wavetable oscillator.
package wlo_pkg;

    localparam int TABLE_DEPTH    = 4096;
    localparam int ADDR_BITS      = $clog2(TABLE_DEPTH);
    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC_BITS      = 16;
    localparam int LEN_BITS       = ADDR_BITS + 1;
    localparam int PHASE_BITS     = ADDR_BITS + FRAC_BITS;
    localparam int STEP_BITS      = PHASE_BITS + 1;
    localparam int BASE_BITS      = 29;
    localparam int GAIN_BITS      = 17;
    localparam int NOTE_BITS      = 7;
    localparam int VEL_BITS       = 8;
    localparam int OP_BITS        = 3;
    localparam int ROM_BITS       = 17;
    localparam int PROD_BITS      = BASE_BITS + ROM_BITS;
    localparam int ACC_BITS       = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int LERP_BITS      = ACC_BITS + 1;
    localparam int MIX_BITS       = ACC_BITS + GAIN_BITS + 1;
    localparam int CNT_BITS       = $clog2(PHASE_BITS);
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = BASE_BITS;
    localparam int CMD_DEPTH      = 2;
    localparam int OUT_DEPTH      = 2;

    localparam logic [LEN_BITS-1:0]  LENGTH_RESET = LEN_BITS'(4096);
    localparam logic [BASE_BITS-1:0] BASE_RESET   = BASE_BITS'(2460658);
    localparam logic [LEN_BITS-1:0]  LEN_MIN      = LEN_BITS'(2);
    localparam logic [LEN_BITS-1:0]  LEN_MAX      = LEN_BITS'(TABLE_DEPTH);

    localparam int VEL_MAX     = 127;
    localparam int GAIN_MULT   = 258;
    localparam int GAIN_BIAS   = 63;
    localparam int NOTE_OFFSET = 3;
    localparam int OCT_RECIP   = 43;
    localparam int OCT_SHIFT   = 9;
    localparam int OCT_BIAS    = 6;
    localparam int SH_BASE     = FRAC_BITS + OCT_BIAS;

    typedef enum logic [OP_BITS-1:0] {
        OP_WRITE    = 3'd0,
        OP_NOTE_ON  = 3'd1,
        OP_NOTE_OFF = 3'd2,
        OP_SILENCE  = 3'd3,
        OP_TICK     = 3'd4
    } op_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_TABLE_LENGTH   = 1'b0,
        CFG_BASE_INCREMENT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [OP_BITS-1:0]            operation;
        logic [ADDR_BITS-1:0]          table_address;
        logic signed [SAMPLE_BITS-1:0] table_value;
        logic [NOTE_BITS-1:0]          note;
        logic [VEL_BITS-1:0]           velocity;
    } request_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sounding;
        logic                          key_held;
    } result_t;

    typedef struct packed {
        op_t                           op;
        logic [ADDR_BITS-1:0]          addr;
        logic signed [SAMPLE_BITS-1:0] value;
        logic [NOTE_BITS-1:0]          note;
        logic [VEL_BITS-1:0]           velocity;
    } cmd_t;

    function automatic logic [ROM_BITS-1:0] semitone(input logic [3:0] s);
        logic [ROM_BITS-1:0] r;
        case (s)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd69433;
            4'd2:    r = 17'd73562;
            4'd3:    r = 17'd77936;
            4'd4:    r = 17'd82570;
            4'd5:    r = 17'd87480;
            4'd6:    r = 17'd92682;
            4'd7:    r = 17'd98193;
            4'd8:    r = 17'd104032;
            4'd9:    r = 17'd110218;
            4'd10:   r = 17'd116772;
            4'd11:   r = 17'd123715;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/wlo_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wlo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/wlo_front.sv
// Front end: accepts request transactions, drops unknown operations, queues commands.
module wlo_front
    import wlo_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  request_t request,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);

    localparam int PTR_BITS   = $clog2(CMD_DEPTH);
    localparam int COUNT_BITS = $clog2(CMD_DEPTH + 1);

    cmd_t                  queue_reg [CMD_DEPTH];
    logic [PTR_BITS-1:0]   wr_reg, wr_next;
    logic [PTR_BITS-1:0]   rd_reg, rd_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  known;
    logic                  store;
    cmd_t                  entry;

    always_comb
    begin
        case (op_t'(request.operation))
            OP_WRITE, OP_NOTE_ON, OP_NOTE_OFF, OP_SILENCE, OP_TICK: known = 1'b1;
            default:                                                known = 1'b0;
        endcase
    end

    assign full      = (count_reg == COUNT_BITS'(CMD_DEPTH));
    assign store     = push && !full && known;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_reg];

    assign entry.op       = op_t'(request.operation);
    assign entry.addr     = request.table_address;
    assign entry.value    = request.table_value;
    assign entry.note     = request.note;
    assign entry.velocity = request.velocity;

    always_comb
    begin
        wr_next    = store ? wr_reg + 1'b1 : wr_reg;
        rd_next    = cmd_pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg;
        if (store && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!store && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            queue_reg[wr_reg] <= entry;
        end
    end

endmodule

FILE: sv/wlo_back.sv
// Back end: voice sequencer with table RAM, pitch and gain setup, interpolation, result queue.
module wlo_back
    import wlo_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    input  cmd_t                      cmd,
    output logic                      cmd_pop,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic                      empty,
    input  logic                      pop,
    output result_t                   result
);

    localparam int OPTR_BITS  = $clog2(OUT_DEPTH);
    localparam int OCNT_BITS  = $clog2(OUT_DEPTH + 1);
    localparam int SUM_BITS   = PROD_BITS + 1;
    localparam int E_BITS     = NOTE_BITS + 1;
    localparam int OPROD_BITS = E_BITS + 6;
    localparam int SH_BITS    = 5;
    localparam int VTMP_BITS  = VEL_BITS + 2;

    localparam logic signed [MIX_BITS-1:0] ROUND_MIX = MIX_BITS'(64'd1 << (FRAC_BITS + 14));
    localparam logic signed [MIX_BITS-1:0] SMP_HI    = MIX_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [MIX_BITS-1:0] SMP_LO    = ~SMP_HI;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL   = 9'b000000010,
        ST_SCALE = 9'b000000100,
        ST_MOD   = 9'b000001000,
        ST_RDA   = 9'b000010000,
        ST_RDB   = 9'b000100000,
        ST_LERP  = 9'b001000000,
        ST_GAIN  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [LEN_BITS-1:0]    length_reg, length_next;
    logic [BASE_BITS-1:0]   base_reg, base_next;
    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [GAIN_BITS-1:0]   gain_reg, gain_next;
    logic                   playing_reg, playing_next;
    logic                   gate_reg, gate_next;
    logic [OPTR_BITS-1:0]   out_wr_reg, out_wr_next;
    logic [OPTR_BITS-1:0]   out_rd_reg, out_rd_next;
    logic [OCNT_BITS-1:0]   out_count_reg, out_count_next;

    logic [3:0]                    oct_reg, oct_next;
    logic [3:0]                    semi_reg, semi_next;
    logic [PROD_BITS-1:0]          mul_reg, mul_next;
    logic [PHASE_BITS-1:0]         ph_reg, ph_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic signed [SAMPLE_BITS-1:0] a_reg, a_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic signed [MIX_BITS-1:0]    mix_reg, mix_next;
    result_t                       out_mem_reg [OUT_DEPTH];

    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                  out_push;
    logic                  out_pop;
    result_t               out_item;

    logic [LEN_BITS-1:0]   eff_len;
    logic [STEP_BITS-1:0]  lenf;
    logic [ADDR_BITS-1:0]  il;
    logic [LEN_BITS-1:0]   il_inc;
    logic [ADDR_BITS-1:0]  ir;
    logic [STEP_BITS-1:0]  mod_t;
    logic [STEP_BITS-1:0]  mod_sub;
    logic [STEP_BITS-1:0]  adv;
    logic [STEP_BITS-1:0]  adv_sub;
    logic [PHASE_BITS-1:0] adv_wrap;

    logic [VEL_BITS-2:0]   vel;
    logic [VTMP_BITS-1:0]  vel_t;
    logic [GAIN_BITS-1:0]  gain_calc;
    logic [E_BITS-1:0]     e;
    logic [OPROD_BITS-1:0] oct_prod;
    logic [3:0]            oct_calc;
    logic [E_BITS-1:0]     semi_full;

    logic [SH_BITS-1:0]    sh;
    logic [SUM_BITS-1:0]   round_add;
    logic [SUM_BITS-1:0]   scaled;
    logic [STEP_BITS-1:0]  step_sat;

    logic signed [SAMPLE_BITS:0]     diff;
    logic signed [SAMPLE_BITS:0]     frac_s;
    logic signed [LERP_BITS-1:0]     a_ext;
    logic signed [LERP_BITS-1:0]     lerp_prod;
    logic signed [LERP_BITS-1:0]     lerp_sum;
    logic signed [MIX_BITS-1:0]      rounded;
    logic signed [MIX_BITS-1:0]      shifted;
    logic signed [SAMPLE_BITS-1:0]   smp;

    wlo_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.addr),
        .wdata (cmd.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (length_reg < LEN_MIN)
        begin
            eff_len = LEN_MIN;
        end
        else if (length_reg > LEN_MAX)
        begin
            eff_len = LEN_MAX;
        end
        else
        begin
            eff_len = length_reg;
        end
    end

    assign lenf   = {eff_len, {FRAC_BITS{1'b0}}};
    assign il     = ph_reg[PHASE_BITS-1:FRAC_BITS];
    assign il_inc = {1'b0, il} + 1'b1;
    assign ir     = (il_inc == eff_len) ? '0 : il_inc[ADDR_BITS-1:0];

    assign mod_t   = {ph_reg, phase_reg[PHASE_BITS-1]};
    assign mod_sub = mod_t - lenf;

    assign adv      = {1'b0, ph_reg} + step_reg;
    assign adv_sub  = adv - lenf;
    assign adv_wrap = (adv >= lenf) ? adv_sub[PHASE_BITS-1:0] : adv[PHASE_BITS-1:0];

    // gain = round(vel * 32768 / 127) = 258 * vel + floor((2 * vel + 63) / 127)
    assign vel   = (cmd.velocity > VEL_BITS'(VEL_MAX)) ? (VEL_BITS-1)'(VEL_MAX)
                                                      : cmd.velocity[VEL_BITS-2:0];
    assign vel_t = {2'b00, vel, 1'b0} + VTMP_BITS'(GAIN_BIAS);
    always_comb
    begin
        gain_calc = GAIN_BITS'(vel) * GAIN_BITS'(GAIN_MULT);
        if (vel_t >= VTMP_BITS'(2 * VEL_MAX))
        begin
            gain_calc = gain_calc + GAIN_BITS'(2);
        end
        else if (vel_t >= VTMP_BITS'(VEL_MAX))
        begin
            gain_calc = gain_calc + GAIN_BITS'(1);
        end
    end

    // octave = (note + 3) / 12 by reciprocal, semitone = remainder
    assign e         = {1'b0, cmd.note} + E_BITS'(NOTE_OFFSET);
    assign oct_prod  = OPROD_BITS'(e) * OPROD_BITS'(OCT_RECIP);
    assign oct_calc  = oct_prod[OCT_SHIFT +: 4];
    assign semi_full = e - ({1'b0, oct_calc, 3'b000} + {2'b00, oct_calc, 2'b00});

    assign sh        = SH_BITS'(SH_BASE) - {1'b0, oct_reg};
    assign round_add = SUM_BITS'(1) << (sh - 1'b1);
    assign scaled    = ({1'b0, mul_reg} + round_add) >> sh;
    assign step_sat  = (scaled > SUM_BITS'(lenf)) ? lenf : scaled[STEP_BITS-1:0];

    assign diff      = {ram_rdata[SAMPLE_BITS-1], ram_rdata} - {a_reg[SAMPLE_BITS-1], a_reg};
    assign frac_s    = {1'b0, ph_reg[FRAC_BITS-1:0]};
    assign a_ext     = {{(LERP_BITS - SAMPLE_BITS - FRAC_BITS){a_reg[SAMPLE_BITS-1]}},
                        a_reg, {FRAC_BITS{1'b0}}};
    assign lerp_prod = diff * frac_s;
    assign lerp_sum  = a_ext + lerp_prod;

    assign rounded = mix_reg + ROUND_MIX;
    assign shifted = rounded >>> (FRAC_BITS + 15);
    always_comb
    begin
        if (shifted > SMP_HI)
        begin
            smp = SMP_HI[SAMPLE_BITS-1:0];
        end
        else if (shifted < SMP_LO)
        begin
            smp = SMP_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            smp = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign out_pop = pop && !empty;
    assign empty   = (out_count_reg == '0);
    assign result  = out_mem_reg[out_rd_reg];

    always_comb
    begin
        state_next   = state_reg;
        length_next  = length_reg;
        base_next    = base_reg;
        phase_next   = phase_reg;
        step_next    = step_reg;
        gain_next    = gain_reg;
        playing_next = playing_reg;
        gate_next    = gate_reg;
        oct_next     = oct_reg;
        semi_next    = semi_reg;
        mul_next     = mul_reg;
        ph_next      = ph_reg;
        cnt_next     = cnt_reg;
        a_next       = a_reg;
        acc_next     = acc_reg;
        mix_next     = mix_reg;
        cmd_pop      = 1'b0;
        ram_we       = 1'b0;
        ram_raddr    = il;
        out_push     = 1'b0;
        out_item.sample   = '0;
        out_item.sounding = playing_reg;
        out_item.key_held = gate_reg;

        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TABLE_LENGTH:   length_next = cfg_data[LEN_BITS-1:0];
                CFG_BASE_INCREMENT: base_next   = cfg_data[BASE_BITS-1:0];
                default:            length_next = length_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_WRITE:
                        begin
                            cmd_pop = 1'b1;
                            ram_we  = 1'b1;
                        end
                        OP_NOTE_ON:
                        begin
                            cmd_pop      = 1'b1;
                            gain_next    = gain_calc;
                            oct_next     = oct_calc;
                            semi_next    = semi_full[3:0];
                            phase_next   = '0;
                            playing_next = 1'b1;
                            gate_next    = 1'b1;
                            state_next   = ST_MUL;
                        end
                        OP_NOTE_OFF:
                        begin
                            cmd_pop   = 1'b1;
                            gate_next = 1'b0;
                        end
                        OP_SILENCE:
                        begin
                            cmd_pop      = 1'b1;
                            gate_next    = 1'b0;
                            playing_next = 1'b0;
                        end
                        OP_TICK:
                        begin
                            if (out_count_reg != OCNT_BITS'(OUT_DEPTH))
                            begin
                                cmd_pop = 1'b1;
                                if (!playing_reg)
                                begin
                                    out_push = 1'b1;
                                end
                                else if ({1'b0, phase_reg} >= lenf)
                                begin
                                    ph_next    = '0;
                                    cnt_next   = CNT_BITS'(PHASE_BITS - 1);
                                    state_next = ST_MOD;
                                end
                                else
                                begin
                                    ph_next    = phase_reg;
                                    state_next = ST_RDA;
                                end
                            end
                        end
                        default: cmd_pop = 1'b1;
                    endcase
                end
            end
            ST_MUL:
            begin
                mul_next   = PROD_BITS'(base_reg) * PROD_BITS'(semitone(semi_reg));
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                step_next  = step_sat;
                state_next = ST_IDLE;
            end
            ST_MOD:
            begin
                // restoring remainder, one phase bit per cycle
                ph_next    = (mod_t >= lenf) ? mod_sub[PHASE_BITS-1:0] : mod_t[PHASE_BITS-1:0];
                phase_next = phase_reg << 1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_RDA;
                end
            end
            ST_RDA:
            begin
                ram_raddr  = il;
                state_next = ST_RDB;
            end
            ST_RDB:
            begin
                ram_raddr  = ir;
                a_next     = ram_rdata;
                state_next = ST_LERP;
            end
            ST_LERP:
            begin
                acc_next   = lerp_sum[ACC_BITS-1:0];
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                mix_next   = acc_reg * $signed({1'b0, gain_reg});
                phase_next = adv_wrap;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                out_push        = 1'b1;
                out_item.sample = smp;
                state_next      = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        out_wr_next    = out_push ? out_wr_reg + 1'b1 : out_wr_reg;
        out_rd_next    = out_pop ? out_rd_reg + 1'b1 : out_rd_reg;
        out_count_next = out_count_reg;
        if (out_push && !out_pop)
        begin
            out_count_next = out_count_reg + 1'b1;
        end
        else if (!out_push && out_pop)
        begin
            out_count_next = out_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            length_reg    <= LENGTH_RESET;
            base_reg      <= BASE_RESET;
            phase_reg     <= '0;
            step_reg      <= '0;
            gain_reg      <= '0;
            playing_reg   <= 1'b0;
            gate_reg      <= 1'b0;
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            base_reg      <= base_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            gain_reg      <= gain_next;
            playing_reg   <= playing_next;
            gate_reg      <= gate_next;
            out_wr_reg    <= out_wr_next;
            out_rd_reg    <= out_rd_next;
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oct_reg  <= oct_next;
        semi_reg <= semi_next;
        mul_reg  <= mul_next;
        ph_reg   <= ph_next;
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        acc_reg  <= acc_next;
        mix_reg  <= mix_next;
        if (out_push)
        begin
            out_mem_reg[out_wr_reg] <= out_item;
        end
    end

endmodule

FILE: sv/wavetable_lerp_oscillator.sv
// Top level of the wavetable oscillator: command queue, voice sequencer, checks.
// Sample path: a sounding tick runs 5 table and math steps after dispatch; when the phase
//   must first be reduced after the length shrank, a restoring remainder runs before them.
// Ticks: the next command waits until a tick is done, paced by the two reads of the
//   single-read-port RAM and the two multiplies; ticks stall on a full result queue.
// Reset: clears queues, voice state and control; registers take 4096 and 2460658; the table
//   RAM is not cleared and holds unknown data until written.
module wavetable_lerp_oscillator
    import wlo_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  request_t                  request,
    output logic                      empty,
    input  logic                      pop,
    output result_t                   result,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    wlo_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    wlo_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from an empty queue");

    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.sounding) |-> (result.sample == '0))
        else $error("nonzero sample while not sounding");

    a_gate_sounds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.key_held) |-> result.sounding)
        else $error("key held without a sounding note");

endmodule
